// File: src/fpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared widths and constants for the flow pair counter.
// ----------------------------------------------------------------------------
package fpc_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TOP_MAX       = 10;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int KEY_W         = 64;
    localparam int PKT_W         = 32;
    localparam int BYTE_W        = 48;
    localparam int RC_W          = 4;
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(TOP_MAX);
    localparam logic FUNC_COUNT  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;
endpackage
`default_nettype wire

// File: src/fpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module fpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: src/flow_pair_counter_top_k.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flow_pair_counter_top_k
// Flow pair packet/byte counter with top-K report.
// ----------------------------------------------------------------------------
// Input channel (valid/stall): func 0 counts a packet, func 1 requests a
// report. Output channel (valid/stall) carries one item per reported flow,
// last marks the final item. cfg channel (valid/ready) writes report_count.
// Flows live in one RAM of key, packet and byte count, filled densely.
// A packet scans the used entries, one read per cycle, comparing both the
// forward and reversed key, then writes back. A report makes one full scan
// per rank and delivers each rank's item before the next scan.
// The block takes one item at a time; in_stall is high while busy.
// Reset empties the table and clears the overflow flag at once (fill count,
// no clearing pass). A stalled output holds its item and the scan waits.
// ----------------------------------------------------------------------------
module flow_pair_counter_top_k
    import fpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              func,
    input  wire logic [31:0]       src_addr,
    input  wire logic [31:0]       dst_addr,
    input  wire logic [15:0]       length,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   entry_valid,
    output logic [3:0]             rank,
    output logic [31:0]            addr_a,
    output logic [31:0]            addr_b,
    output logic [31:0]            packet_total,
    output logic [47:0]            byte_total,
    output logic                   overflow,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [RC_W-1:0]   cfg_data
);
    localparam int W = KEY_W + PKT_W + BYTE_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_RSCAN, S_ROUT, S_WAIT} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              ovf_reg;
    logic [RC_W-1:0]   rc_reg;
    logic [31:0]       src_reg, dst_reg;
    logic [15:0]       len_reg;
    logic [CNT_W-1:0]  i_reg;       // address issued
    logic              rv_reg;      // read data valid this cycle
    logic [IDX_W-1:0]  ri_reg;      // index of data on rdata
    logic              fwd_hit_reg, rev_hit_reg;
    logic [IDX_W-1:0]  fwd_idx_reg, rev_idx_reg;
    logic [3:0]        r_reg, want_reg;
    logic [PKT_W-1:0]  prev_pk_reg;
    logic [IDX_W-1:0]  prev_idx_reg;
    logic              best_v_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [W-1:0]      best_reg;

    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [W-1:0]      wdata, rdata;

    logic [KEY_W-1:0]  r_key;
    logic [PKT_W-1:0]  r_pk;
    logic [BYTE_W-1:0] r_by;
    logic [KEY_W-1:0]  fwd_key, rev_key;
    logic              eligible;
    logic [IDX_W-1:0]  upd_idx;
    logic [PKT_W-1:0]  new_pk;
    logic [BYTE_W:0]   by_sum;
    logic [BYTE_W-1:0] new_by;

    assign r_key   = rdata[W-1 -: KEY_W];
    assign r_pk    = rdata[BYTE_W +: PKT_W];
    assign r_by    = rdata[BYTE_W-1:0];
    assign fwd_key = {src_reg, dst_reg};
    assign rev_key = {dst_reg, src_reg};
    assign eligible = (r_reg == 4'd0) || (r_pk < prev_pk_reg) ||
                      ((r_pk == prev_pk_reg) && (ri_reg > prev_idx_reg));

    // update source: hit entry (read on addr) or a fresh one
    assign upd_idx = fwd_hit_reg ? fwd_idx_reg : rev_hit_reg ? rev_idx_reg
                   : used_reg[IDX_W-1:0];
    assign new_pk  = (fwd_hit_reg || rev_hit_reg) ?
                     ((r_pk == '1) ? r_pk : r_pk + 1'b1) : PKT_W'(1);
    assign by_sum  = (fwd_hit_reg || rev_hit_reg) ?
                     ({1'b0, r_by} + (BYTE_W+1)'(len_reg)) : (BYTE_W+1)'(len_reg);
    assign new_by  = by_sum[BYTE_W] ? '1 : by_sum[BYTE_W-1:0];

    always_comb
    begin
        we    = 1'b0;
        addr  = i_reg[IDX_W-1:0];
        wdata = {(fwd_hit_reg || rev_hit_reg) ? r_key : rev_key, new_pk, new_by};
        if (state_reg == S_UPD)
        begin
            addr = upd_idx;
            we   = rv_reg && ((fwd_hit_reg || rev_hit_reg) ||
                   (used_reg < CNT_W'(TABLE_ENTRIES)));
        end
    end

    fpc_ram #(.WIDTH(W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_ROUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ovf_reg   <= 1'b0;
            rc_reg    <= RC_RESET;
            rv_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            ri_reg <= i_reg[IDX_W-1:0];
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        rc_reg <= cfg_data;
                    end
                    if (in_valid)
                    begin
                        src_reg     <= src_addr;
                        dst_reg     <= dst_addr;
                        len_reg     <= length;
                        i_reg       <= '0;
                        fwd_hit_reg <= 1'b0;
                        rev_hit_reg <= 1'b0;
                        r_reg       <= '0;
                        best_v_reg  <= 1'b0;
                        want_reg    <= (cfg_valid ? cfg_data : rc_reg) == '0 ? 4'd1 :
                                       ((cfg_valid ? cfg_data : rc_reg) > 4'(TOP_MAX) ?
                                        4'(TOP_MAX) : (cfg_valid ? cfg_data : rc_reg));
                        state_reg   <= (func == FUNC_REPORT) ? S_RSCAN : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (rv_reg)
                    begin
                        if (r_key == fwd_key && !fwd_hit_reg)
                        begin
                            fwd_hit_reg <= 1'b1;
                            fwd_idx_reg <= ri_reg;
                        end
                        if (r_key == rev_key && !rev_hit_reg)
                        begin
                            rev_hit_reg <= 1'b1;
                            rev_idx_reg <= ri_reg;
                        end
                    end
                    if (i_reg < used_reg)
                    begin
                        rv_reg <= 1'b1;
                        i_reg  <= i_reg + 1'b1;
                    end
                    else if (!rv_reg)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    // first issue the read of the hit entry, then write once rv_reg is set
                    if (!rv_reg)
                    begin
                        rv_reg <= 1'b1;
                    end
                    else
                    begin
                        if (!(fwd_hit_reg || rev_hit_reg))
                        begin
                            if (used_reg < CNT_W'(TABLE_ENTRIES))
                                used_reg <= used_reg + 1'b1;
                            else
                                ovf_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_RSCAN:
                begin
                    if (rv_reg && eligible &&
                        (!best_v_reg || r_pk > best_reg[BYTE_W +: PKT_W]))
                    begin
                        best_v_reg   <= 1'b1;
                        best_idx_reg <= ri_reg;
                        best_reg     <= rdata;
                    end
                    if (i_reg < used_reg)
                    begin
                        rv_reg <= 1'b1;
                        i_reg  <= i_reg + 1'b1;
                    end
                    else if (!rv_reg)
                    begin
                        state_reg <= S_ROUT;
                    end
                end
                S_ROUT:
                begin
                    if (!out_stall)
                    begin
                        if (!best_v_reg || last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            prev_pk_reg  <= best_reg[BYTE_W +: PKT_W];
                            prev_idx_reg <= best_idx_reg;
                            r_reg        <= r_reg + 1'b1;
                            best_v_reg   <= 1'b0;
                            i_reg        <= '0;
                            state_reg    <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    // next rank: rescan; if none is found, an item with entry_valid low ends it
                    state_reg <= S_RSCAN;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output view: a report with no further flow ends at the previous item,
    // so look ahead is done by knowing remaining count vs used entries
    logic [CNT_W-1:0] reported;
    assign reported = CNT_W'(r_reg) + 1'b1;

    assign entry_valid  = best_v_reg;
    assign rank         = best_v_reg ? r_reg : 4'd0;
    assign addr_a       = best_v_reg ? best_reg[W-1 -: 32] : 32'd0;
    assign addr_b       = best_v_reg ? best_reg[W-33 -: 32] : 32'd0;
    assign packet_total = best_v_reg ? best_reg[BYTE_W +: PKT_W] : 32'd0;
    assign byte_total   = best_v_reg ? best_reg[BYTE_W-1:0] : 48'd0;
    assign overflow     = ovf_reg;
    // every valid entry is reported once, so flows run out at rank used-1
    assign last         = !best_v_reg || (r_reg + 1'b1 == want_reg) ||
                          (reported >= used_reg);

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("busy without stall");
    a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_ENTRIES)) else $error("fill count overrun");
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ovf_reg) |-> ovf_reg) else $error("overflow flag cleared");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("output dropped");
endmodule
`default_nettype wire
